@@ rtl/shortcut_binding_table_top_assert.svh @@
`ifndef SHORTCUT_BINDING_TABLE_TOP_ASSERT_SVH
`define SHORTCUT_BINDING_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SBT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SBT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sbt_pkg.sv @@
package sbt_pkg;

    localparam int unsigned DEFAULT_DEPTH = 64;
    localparam int unsigned MOD_W = 8;
    localparam int unsigned KEY_W = 16;
    localparam int unsigned ACT_W = 5;
    localparam int unsigned ARG_W = 16;
    localparam int unsigned CMD_W = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned IN_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_BIND   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } sbt_op_t;

    localparam logic [CFG_IDX_W-1:0] REG_CTRL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUPER = 2'd3;

    localparam logic [MOD_W-1:0] CTRL_MASK_RST  = 8'd17;
    localparam logic [MOD_W-1:0] SHIFT_MASK_RST = 8'd34;
    localparam logic [MOD_W-1:0] ALT_MASK_RST   = 8'd68;
    localparam logic [MOD_W-1:0] SUPER_MASK_RST = 8'd136;

    typedef struct packed {
        logic [MOD_W-1:0]        mods;
        logic [KEY_W-1:0]        key;
        logic [ACT_W-1:0]        action;
        logic signed [ARG_W-1:0] arg;
    } sbt_entry_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic take_hit;
        logic update;
        logic append;
        logic reject;
        logic shift;
        logic dec;
        logic clear;
        logic finish;
    } sbt_cmd_t;

    typedef struct packed {
        sbt_op_t op;
        logic    act_zero;
        logic    hit;
        logic    miss;
        logic    full;
        logic    shift_done;
        logic    out_free;
    } sbt_status_t;

    function automatic logic [MOD_W-1:0] fold_mods(
        input logic [MOD_W-1:0] raw,
        input logic [MOD_W-1:0] m_ctrl,
        input logic [MOD_W-1:0] m_shift,
        input logic [MOD_W-1:0] m_alt,
        input logic [MOD_W-1:0] m_super
    );
        logic [MOD_W-1:0] m;
        m = '0;
        if ((raw & m_ctrl) != '0) m = m | m_ctrl;
        if ((raw & m_shift) != '0) m = m | m_shift;
        if ((raw & m_alt) != '0) m = m | m_alt;
        if ((raw & m_super) != '0) m = m | m_super;
        return m;
    endfunction

endpackage

@@ rtl/shortcut_binding_table_top.sv @@
// Transaction flow, N = stored entries: a lookup or bind scans the N entries, one entry per
// cycle, and stops at the first hit or after the last entry.
// Unbind hit shifts later entries down, one per cycle. Clear and the unused command go
// straight from the scan state to finish. m_tvalid rises with s_tready; one transaction in
// flight, and a result waiting in the output register stalls only the next one's finish.
// Reset (aresetn, synchronous, active low) empties the table and restores masks.
module shortcut_binding_table_top
    import sbt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEFAULT_DEPTH,
    localparam int unsigned CNT_W    = $clog2(TABLE_DEPTH + 1),
    localparam int unsigned OUT_TD_W = ((1 + ACT_W + ARG_W + 1 + CNT_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // command, modifier_bits, key_code, action_code, argument
    input  logic [IN_TDATA_W-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // found, bound_action, bound_argument, accepted, entry_count
    output logic [OUT_TD_W-1:0]   m_tdata
);

    sbt_cmd_t    cmd;
    sbt_status_t status;

    sbt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sbt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CNT_W       (CNT_W),
        .OUT_TD_W    (OUT_TD_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ rtl/sbt_ctrl.sv @@
module sbt_ctrl
    import sbt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  sbt_status_t status,
    output sbt_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.op == OP_CLEAR) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_FINISH;
                end else if (status.op == OP_NONE) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.scan = 1'b1;
                    if (status.hit) begin
                        cmd.take_hit = 1'b1;
                        if (status.op == OP_BIND && status.act_zero) begin
                            state_next = ST_SHIFT;
                        end else begin
                            cmd.update = (status.op == OP_BIND);
                            state_next = ST_FINISH;
                        end
                    end else if (status.miss) begin
                        if (status.op == OP_BIND && !status.act_zero) begin
                            cmd.reject = status.full;
                            cmd.append = !status.full;
                        end
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                if (status.shift_done) begin
                    cmd.dec    = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/sbt_datapath.sv @@
module sbt_datapath
    import sbt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEFAULT_DEPTH,
    parameter int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1),
    parameter int unsigned OUT_TD_W    = ((1 + ACT_W + ARG_W + 1 + CNT_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sbt_cmd_t              cmd,
    output sbt_status_t           status,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_TD_W-1:0]   m_tdata
);

`include "shortcut_binding_table_top_assert.svh"

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [MOD_W-1:0] ctrl_mask_reg;
    logic [MOD_W-1:0] shift_mask_reg;
    logic [MOD_W-1:0] alt_mask_reg;
    logic [MOD_W-1:0] super_mask_reg;

    sbt_op_t                 op_reg;
    logic [MOD_W-1:0]        mods_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [ACT_W-1:0]        action_reg;
    logic signed [ARG_W-1:0] arg_reg;

    sbt_entry_t mem [TABLE_DEPTH];
    sbt_entry_t rd_data_reg;
    sbt_entry_t mem_wdata;
    logic       mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] rd_addr;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] sh_idx_reg;
    logic [CNT_W-1:0] sh_plus1;
    logic [AW-1:0]    cmp_idx_reg;
    logic [AW-1:0]    sh_wr_addr_reg;
    logic             cmp_vld_reg;
    logic             sh_wr_vld_reg;

    logic                    found_reg;
    logic                    accepted_reg;
    logic [ACT_W-1:0]        bact_reg;
    logic signed [ARG_W-1:0] barg_reg;

    logic                    out_found_reg;
    logic                    out_accepted_reg;
    logic [ACT_W-1:0]        out_bact_reg;
    logic signed [ARG_W-1:0] out_barg_reg;
    logic [CNT_W-1:0]        out_cnt_reg;
    logic                    m_tvalid_reg;

    logic scan_issue;
    logic shift_more;
    logic shift_issue;
    logic match;
    logic full;
    logic out_free;

    // config mask registers; s_tdata fields, low to high: command, modifier_bits, key_code,
    // action_code, argument
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_mask_reg  <= CTRL_MASK_RST;
            shift_mask_reg <= SHIFT_MASK_RST;
            alt_mask_reg   <= ALT_MASK_RST;
            super_mask_reg <= SUPER_MASK_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_CTRL:  ctrl_mask_reg  <= cfg_wdata;
                REG_SHIFT: shift_mask_reg <= cfg_wdata;
                REG_ALT:   alt_mask_reg   <= cfg_wdata;
                REG_SUPER: super_mask_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= sbt_op_t'(s_tdata[1:0]);
            mods_reg   <= fold_mods(s_tdata[9:2], ctrl_mask_reg, shift_mask_reg,
                                    alt_mask_reg, super_mask_reg);
            key_reg    <= s_tdata[25:10];
            action_reg <= s_tdata[30:26];
            arg_reg    <= s_tdata[46:31];
        end
    end

    assign sh_plus1    = sh_idx_reg + CNT_W'(1);
    assign scan_issue  = cmd.scan && (rd_idx_reg < cnt_reg);
    assign shift_more  = (sh_plus1 < cnt_reg);
    assign shift_issue = cmd.shift && shift_more;
    assign rd_addr     = shift_issue ? sh_plus1[AW-1:0] : rd_idx_reg[AW-1:0];
    assign match       = (rd_data_reg.mods == mods_reg) && (rd_data_reg.key == key_reg);
    assign full        = (cnt_reg == CNT_W'(TABLE_DEPTH));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cmp_idx_reg;
        mem_wdata = '{mods: mods_reg, key: key_reg, action: action_reg, arg: arg_reg};
        if (cmd.update) begin
            mem_we = 1'b1;
        end else if (cmd.append) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_reg[AW-1:0];
        end else if (sh_wr_vld_reg) begin
            mem_we    = 1'b1;
            mem_waddr = sh_wr_addr_reg;
            mem_wdata = rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // scan and shift pipelines, entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            sh_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            sh_wr_vld_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                rd_idx_reg  <= '0;
                cmp_vld_reg <= 1'b0;
            end else begin
                cmp_vld_reg <= scan_issue;
                if (scan_issue) begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
            end
            if (cmd.take_hit) begin
                sh_idx_reg    <= CNT_W'(cmp_idx_reg);
                sh_wr_vld_reg <= 1'b0;
            end else begin
                sh_wr_vld_reg <= shift_issue;
                if (shift_issue) begin
                    sh_idx_reg <= sh_plus1;
                end
            end
            if (cmd.clear) begin
                cnt_reg <= '0;
            end else if (cmd.append) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (cmd.dec) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_issue) begin
            cmp_idx_reg <= rd_idx_reg[AW-1:0];
        end
        if (shift_issue) begin
            sh_wr_addr_reg <= sh_idx_reg[AW-1:0];
        end
    end

    // per-transaction result
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            found_reg    <= 1'b0;
            accepted_reg <= 1'b1;
            bact_reg     <= '0;
            barg_reg     <= '0;
        end else begin
            if (cmd.take_hit) begin
                found_reg <= 1'b1;
                if (op_reg == OP_LOOKUP) begin
                    bact_reg <= rd_data_reg.action;
                    barg_reg <= rd_data_reg.arg;
                end
            end
            if (cmd.reject) begin
                accepted_reg <= 1'b0;
            end
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_found_reg    <= found_reg;
            out_accepted_reg <= accepted_reg;
            out_bact_reg     <= bact_reg;
            out_barg_reg     <= barg_reg;
            out_cnt_reg      <= cnt_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TD_W'({out_cnt_reg, out_accepted_reg, out_barg_reg,
                                 out_bact_reg, out_found_reg});

    assign status.op         = op_reg;
    assign status.act_zero   = (action_reg == '0);
    assign status.hit        = cmp_vld_reg && match;
    assign status.miss       = !cmp_vld_reg && (rd_idx_reg == cnt_reg);
    assign status.full       = full;
    assign status.shift_done = !shift_more && !sh_wr_vld_reg;
    assign status.out_free   = out_free;

    `SBT_ASSERT_NOW(a_append_room, aclk, aresetn, cmd.append, !full, "append into full table")
    `SBT_ASSERT_NOW(a_dec_nonzero, aclk, aresetn, cmd.dec, cnt_reg != '0, "remove from empty table")
    `SBT_ASSERT_NOW(a_finish_free, aclk, aresetn, cmd.finish, out_free, "result overwritten")
    `SBT_ASSERT_NOW(a_shift_addr, aclk, aresetn, sh_wr_vld_reg,
                    CNT_W'(sh_wr_addr_reg) < cnt_reg, "shift write beyond count")

endmodule

@@ tb/tb.sv @@
module tb;
    import sbt_pkg::*;

    localparam int unsigned DEPTH        = DEFAULT_DEPTH;
    localparam int unsigned CNT_W        = $clog2(DEPTH + 1);
    localparam int unsigned OUT_W        = ((1 + ACT_W + ARG_W + 1 + CNT_W + 7) / 8) * 8;
    localparam int unsigned REQ_W        = CMD_W + MOD_W + KEY_W + ACT_W + ARG_W;
    localparam int unsigned F_ACT_LO     = 1;
    localparam int unsigned F_ARG_LO     = F_ACT_LO + ACT_W;
    localparam int unsigned F_ACC        = F_ARG_LO + ARG_W;
    localparam int unsigned F_CNT_LO     = F_ACC + 1;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned HOLD_CYCLES  = 600;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned REPORT_MAX   = 10;

    localparam logic [KEY_W-1:0] KEY_POOL [8] = '{16'h0000, 16'hFFFF, 16'h0041, 16'h8000,
                                                  16'h1234, 16'h00FF, 16'h7FFF, 16'h5A5A};
    localparam logic [MOD_W-1:0] MOD_POOL [6] = '{8'h00, 8'hFF, 8'h01, 8'h10, 8'h22, 8'h80};

    typedef struct {
        sbt_op_t                 op;
        logic [MOD_W-1:0]        mods;
        logic [KEY_W-1:0]        key;
        logic [ACT_W-1:0]        action;
        logic signed [ARG_W-1:0] arg;
    } key_cmd_t;

    typedef struct {
        logic                    found;
        logic [ACT_W-1:0]        action;
        logic signed [ARG_W-1:0] arg;
        logic                    accepted;
        logic [CNT_W-1:0]        count;
    } key_reply_t;

    class shortcut_table_shadow;
        logic [MOD_W-1:0] group_mask [4];
        sbt_entry_t       bindings [$];
        key_reply_t       expected_replies [$];
        int unsigned      mismatches;

        function void reset_state();
            group_mask[0] = CTRL_MASK_RST;
            group_mask[1] = SHIFT_MASK_RST;
            group_mask[2] = ALT_MASK_RST;
            group_mask[3] = SUPER_MASK_RST;
            bindings.delete();
            expected_replies.delete();
            mismatches = 0;
        endfunction

        function void set_mask(int unsigned idx, logic [MOD_W-1:0] value);
            group_mask[idx] = value;
        endfunction

        function logic [MOD_W-1:0] fold(logic [MOD_W-1:0] raw);
            logic [MOD_W-1:0] m;
            m = '0;
            foreach (group_mask[g])
                if ((raw & group_mask[g]) != '0)
                    m = m | group_mask[g];
            return m;
        endfunction

        function int find_binding(logic [MOD_W-1:0] mods, logic [KEY_W-1:0] key);
            foreach (bindings[i])
                if (bindings[i].mods == mods && bindings[i].key == key)
                    return i;
            return -1;
        endfunction

        // called once per accepted input transaction
        function void note_command(key_cmd_t c);
            key_reply_t       r;
            logic [MOD_W-1:0] m;
            int               hit;
            sbt_entry_t       e;
            r = '{found: 1'b0, action: '0, arg: '0, accepted: 1'b1, count: '0};
            m = fold(c.mods);
            hit = find_binding(m, c.key);
            case (c.op)
                OP_LOOKUP: begin
                    if (hit >= 0) begin
                        r.found  = 1'b1;
                        r.action = bindings[hit].action;
                        r.arg    = bindings[hit].arg;
                    end
                end
                OP_BIND: begin
                    if (hit >= 0) begin
                        r.found = 1'b1;
                        if (c.action == '0) begin
                            bindings.delete(hit);
                        end else begin
                            e = bindings[hit];
                            e.action = c.action;
                            e.arg = c.arg;
                            bindings[hit] = e;
                        end
                    end else if (c.action != '0) begin
                        if (bindings.size() >= DEPTH) begin
                            r.accepted = 1'b0;
                        end else begin
                            e.mods = m;
                            e.key = c.key;
                            e.action = c.action;
                            e.arg = c.arg;
                            bindings.push_back(e);
                        end
                    end
                end
                OP_CLEAR: bindings.delete();
                default: ;
            endcase
            r.count = CNT_W'(bindings.size());
            expected_replies.push_back(r);
        endfunction

        function void report_field(string field, longint want, longint got);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
        endfunction

        // called once per accepted result transaction
        function void check_reply(logic [OUT_W-1:0] td);
            key_reply_t got;
            key_reply_t want;
            got.found    = td[0];
            got.action   = td[F_ACT_LO +: ACT_W];
            got.arg      = td[F_ARG_LO +: ARG_W];
            got.accepted = td[F_ACC];
            got.count    = td[F_CNT_LO +: CNT_W];
            if (expected_replies.size() == 0) begin
                report_field("unexpected transaction, entry_count", -1, got.count);
                return;
            end
            want = expected_replies.pop_front();
            if (got.found !== want.found)
                report_field("found", want.found, got.found);
            if (got.action !== want.action)
                report_field("bound_action", want.action, got.action);
            if (got.arg !== want.arg)
                report_field("bound_argument", want.arg, got.arg);
            if (got.accepted !== want.accepted)
                report_field("accepted", want.accepted, got.accepted);
            if (got.count !== want.count)
                report_field("entry_count", want.count, got.count);
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;

    shortcut_table_shadow shadow = new();
    bit          steady       = 1'b0;
    bit          hold_replies = 1'b0;
    int unsigned cycles       = 0;

    shortcut_binding_table_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic key_cmd_t make_cmd(sbt_op_t op, logic [MOD_W-1:0] mods,
                                          logic [KEY_W-1:0] key, logic [ACT_W-1:0] action,
                                          logic signed [ARG_W-1:0] arg);
        key_cmd_t c;
        c.op = op;
        c.mods = mods;
        c.key = key;
        c.action = action;
        c.arg = arg;
        return c;
    endfunction

    function automatic key_cmd_t random_cmd();
        key_cmd_t    c;
        int unsigned sel;
        c.mods   = ($urandom_range(0, 3) == 0) ? MOD_W'($urandom) : MOD_POOL[$urandom_range(0, 5)];
        c.key    = ($urandom_range(0, 4) == 0) ? KEY_W'($urandom) : KEY_POOL[$urandom_range(0, 7)];
        c.action = ACT_W'($urandom_range(0, 31));
        c.arg    = ARG_W'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            c.op = OP_LOOKUP;
        end else if (sel < 93) begin
            c.op = OP_BIND;
            if ($urandom_range(0, 3) == 0)
                c.action = '0;
        end else if (sel < 96) begin
            c.op = OP_CLEAR;
        end else begin
            c.op = OP_NONE;
        end
        return c;
    endfunction

    task automatic send_command(key_cmd_t c);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - REQ_W){1'b0}}, c.arg, c.action, c.key, c.mods, c.op};
        do @(posedge aclk); while (!s_tready);
        shadow.note_command(c);
    endtask

    task automatic send_random(int unsigned n);
        repeat (n) send_command(random_cmd());
    endtask

    // wait for every result, block is idle afterwards
    task automatic settle();
        s_tvalid <= 1'b0;
        while (shadow.expected_replies.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic program_masks(logic [MOD_W-1:0] c_m, logic [MOD_W-1:0] s_m,
                                 logic [MOD_W-1:0] a_m, logic [MOD_W-1:0] u_m);
        logic [MOD_W-1:0] vals [4];
        vals = '{c_m, s_m, a_m, u_m};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            shadow.set_mask(i, vals[i]);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // fill to capacity, overflow, update while full, look up and remove some
    task automatic fill_table();
        logic [MOD_W-1:0] fill_mods [DEPTH + 3];
        int unsigned      base;
        int unsigned      k;
        base = $urandom_range(0, 65535 - DEPTH - 3);
        send_command(make_cmd(OP_CLEAR, 8'h00, 16'h0000, 5'd0, 16'sd0));
        for (int i = 0; i < DEPTH + 3; i++) begin
            fill_mods[i] = MOD_W'($urandom);
            send_command(make_cmd(OP_BIND, fill_mods[i], KEY_W'(base + i),
                                  ACT_W'($urandom_range(1, 31)), ARG_W'($urandom)));
        end
        send_command(make_cmd(OP_BIND, fill_mods[0], KEY_W'(base), 5'd31, ARG_W'($urandom)));
        repeat (4) begin
            k = $urandom_range(0, DEPTH + 2);
            send_command(make_cmd(OP_LOOKUP, fill_mods[k], KEY_W'(base + k), 5'd0, 16'sd0));
        end
        repeat (4) begin
            k = $urandom_range(0, DEPTH - 1);
            send_command(make_cmd(OP_BIND, fill_mods[k], KEY_W'(base + k), 5'd0, 16'sd0));
            send_command(make_cmd(OP_LOOKUP, fill_mods[k], KEY_W'(base + k), 5'd0, 16'sd0));
        end
    endtask

    task automatic run_directed();
        send_command(make_cmd(OP_LOOKUP, 8'h00, 16'h0000, 5'd0, 16'sd0));
        send_command(make_cmd(OP_BIND, 8'h00, 16'h0000, 5'd31, 16'sd32767));
        send_command(make_cmd(OP_BIND, 8'hFF, 16'hFFFF, 5'd1, -16'sd32768));
        send_command(make_cmd(OP_LOOKUP, 8'h00, 16'h0000, 5'd0, 16'sd0));
        send_command(make_cmd(OP_LOOKUP, 8'h88, 16'hFFFF, 5'd0, 16'sd0));
        send_command(make_cmd(OP_LOOKUP, 8'h0F, 16'hFFFF, 5'd0, 16'sd0));
        send_command(make_cmd(OP_BIND, 8'h01, 16'h1234, 5'd5, 16'sd100));
        send_command(make_cmd(OP_BIND, 8'h10, 16'h1234, 5'd7, -16'sd1));
        send_command(make_cmd(OP_LOOKUP, 8'h11, 16'h1234, 5'd0, 16'sd0));
        send_command(make_cmd(OP_BIND, 8'h00, 16'h4321, 5'd0, 16'sd55));
        send_command(make_cmd(OP_BIND, 8'h00, 16'h0000, 5'd0, 16'sd0));
        send_command(make_cmd(OP_LOOKUP, 8'hFF, 16'hFFFF, 5'd0, 16'sd0));
        send_command(make_cmd(OP_LOOKUP, 8'h00, 16'h0000, 5'd0, 16'sd0));
        send_command(make_cmd(OP_NONE, 8'hFF, 16'hFFFF, 5'd31, -16'sd1));
        send_command(make_cmd(OP_CLEAR, 8'h00, 16'h0000, 5'd0, 16'sd0));
        send_command(make_cmd(OP_LOOKUP, 8'h11, 16'h1234, 5'd0, 16'sd0));
        send_command(make_cmd(OP_BIND, 8'h40, 16'h8000, 5'd16, 16'sh5555));
        send_command(make_cmd(OP_LOOKUP, 8'h04, 16'h8000, 5'd0, 16'sd0));
    endtask

    initial begin : reply_sink
        int unsigned stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_replies) begin
                hold_replies = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = steady ? 0 : $urandom_range(0, 10);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            shadow.check_reply(m_tdata);
        end
    end

    initial begin
        shadow.reset_state();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        // receiver backs off while the sender keeps pushing
        hold_replies = 1'b1;
        steady = 1'b1;
        send_random(20);
        steady = 1'b0;
        send_random(130);
        fill_table();
        settle();

        program_masks(8'h00, 8'h00, 8'h00, 8'h00);
        steady = 1'b1;
        send_random(120);
        steady = 1'b0;
        settle();

        program_masks(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_random(120);
        settle();

        program_masks(8'h01, 8'h02, 8'h04, 8'h08);
        send_random(130);
        fill_table();
        settle();

        program_masks(MOD_W'($urandom), MOD_W'($urandom), MOD_W'($urandom), MOD_W'($urandom));
        send_random(130);
        settle();

        program_masks(CTRL_MASK_RST, SHIFT_MASK_RST, ALT_MASK_RST, SUPER_MASK_RST);
        send_random(130);

        s_tvalid <= 1'b0;
        while (shadow.expected_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (shadow.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ shortcut_binding_table_top.f @@
+incdir+rtl
rtl/sbt_pkg.sv
rtl/sbt_ctrl.sv
rtl/sbt_datapath.sv
rtl/shortcut_binding_table_top.sv
tb/tb.sv
